@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the node selector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nlb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlb_pkg
// Types and fixed constants shared by the node selector modules.
// ----------------------------------------------------------------------------
package nlb_pkg;

    // Field widths
    localparam int ID_W     = 8;
    localparam int LOAD_W   = 16;
    localparam int ID_SPACE = 1 << ID_W;
    localparam int REQ_W    = 2;
    localparam int ST_W     = 2;
    localparam int NC_W     = 5;

    // Select policy codes
    localparam logic STRAT_RR = 1'b0;
    localparam logic STRAT_LL = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_SELECT = 2'd3
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_WALK = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    // Broadcast control from the sequencer to every list cell
    typedef struct packed {
        logic              walk;  // shift the chain one place toward cell 0
        logic              ins;   // during a walk, re-insert the head at the tail
        logic              add;   // write a new entry at the given position
        logic              upd;   // overwrite the load of matching entries
        logic [ID_W-1:0]   id;
        logic [LOAD_W-1:0] load;
    } t_cell_ctl;

endpackage

@@ src/nlb_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlb_cell
// One list entry: a node id and its load, shifted from the neighbor cell.
// ----------------------------------------------------------------------------
module nlb_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 4
) (
    input  logic                          i_clk,
    input  nlb_pkg::t_cell_ctl            i_ctl,
    input  logic [IDX_W-1:0]              i_pos,
    input  logic [nlb_pkg::ID_W-1:0]      i_next_id,
    input  logic [nlb_pkg::LOAD_W-1:0]    i_next_load,
    input  logic [nlb_pkg::ID_W-1:0]      i_head_id,
    input  logic [nlb_pkg::LOAD_W-1:0]    i_head_load,
    output logic [nlb_pkg::ID_W-1:0]      o_id,
    output logic [nlb_pkg::LOAD_W-1:0]    o_load
);
    import nlb_pkg::*;

    logic [ID_W-1:0]   r_id;
    logic [LOAD_W-1:0] r_load;
    logic              w_at_pos;
    logic              w_match;

    assign w_at_pos = (i_pos == IDX_W'(IDX));
    assign w_match  = (r_id == i_ctl.id);

    // Shift, append or update the entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.walk) begin
            if (i_ctl.ins && w_at_pos) begin
                r_id   <= i_head_id;
                r_load <= i_head_load;
            end else begin
                r_id   <= i_next_id;
                r_load <= i_next_load;
            end
        end else if (i_ctl.add) begin
            if (w_at_pos) begin
                r_id   <= i_ctl.id;
                r_load <= '0;
            end else if (w_match) begin
                r_load <= '0;
            end
        end else if (i_ctl.upd && w_match) begin
            r_load <= i_ctl.load;
        end
    end

    assign o_id   = r_id;
    assign o_load = r_load;

endmodule

@@ src/nlb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlb_ctrl
// Request sequencer: known flags, list length, round-robin pointer, chain walk.
// ----------------------------------------------------------------------------
module nlb_ctrl #(
    parameter int MAX_NODES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nlb_pkg::REQ_W-1:0]     i_req_type,
    input  logic [nlb_pkg::ID_W-1:0]      i_node_id,
    input  logic [nlb_pkg::LOAD_W-1:0]    i_load_value,
    input  logic                          i_strategy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nlb_pkg::ST_W-1:0]      o_status,
    output logic [nlb_pkg::ID_W-1:0]      o_selected_node,
    output logic [nlb_pkg::NC_W-1:0]      o_node_count,
    input  logic [nlb_pkg::ID_W-1:0]      i_head_id,
    input  logic [nlb_pkg::LOAD_W-1:0]    i_head_load,
    output nlb_pkg::t_cell_ctl            o_cell_ctl,
    output logic [$clog2(MAX_NODES)-1:0]  o_pos
);
    import nlb_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    t_state              r_state;
    t_state              n_state;
    t_req                r_req;
    logic [ID_W-1:0]     r_id;
    logic [LOAD_W-1:0]   r_load;
    logic                r_strat;
    logic [CNT_W-1:0]    r_len;
    logic [IDX_W-1:0]    r_rr;
    logic [ID_SPACE-1:0] r_known;
    logic [CNT_W-1:0]    r_step;
    logic [CNT_W-1:0]    r_cur_len;
    logic [CNT_W-1:0]    r_walk_len;
    t_status             r_status;
    logic [ID_W-1:0]     r_sel;
    logic [LOAD_W-1:0]   r_best_load;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ID_W-1:0]     r_out_sel;
    logic [NC_W-1:0]     r_out_count;

    logic                w_known;
    logic [IDX_W-1:0]    w_rr_p;
    logic [CNT_W-1:0]    w_rr_inc;
    logic                w_last;
    logic                w_keep;
    logic                w_has_room;
    logic [CNT_W-1:0]    w_tail;
    logic [CNT_W-1:0]    n_cur_len;
    logic [NC_W+CNT_W-1:0] w_count_ext;
    logic [NC_W-1:0]     w_count;

    // Decode request and walk conditions
    always_comb begin
        w_known     = r_known[r_id];
        w_rr_p      = (CNT_W'(r_rr) < r_len) ? r_rr : '0;
        w_rr_inc    = CNT_W'(w_rr_p) + CNT_W'(1);
        w_last      = (r_step == (r_walk_len - CNT_W'(1)));
        w_keep      = (r_req != REQ_REMOVE) || (i_head_id != r_id);
        w_has_room  = (r_len < CNT_W'(MAX_NODES));
        w_tail      = r_cur_len - CNT_W'(1);
        n_cur_len   = w_keep ? r_cur_len : (r_cur_len - CNT_W'(1));
        w_count_ext = {{NC_W{1'b0}}, r_len};
        w_count     = w_count_ext[NC_W-1:0];
    end

    // Next state
    always_comb begin
        case (r_state)
            S_IDLE: n_state = i_in_valid ? S_EXEC : S_IDLE;
            S_EXEC: begin
                if (((r_req == REQ_REMOVE) && w_known) ||
                    ((r_req == REQ_SELECT) && (r_len != '0))) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WALK: n_state = w_last ? S_OUT : S_WALK;
            S_OUT:  n_state = (!r_out_valid || !i_out_stall) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Drive handshake and cell controls
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_cell_ctl.walk = (r_state == S_WALK);
        o_cell_ctl.ins  = (r_state == S_WALK) && w_keep;
        o_cell_ctl.add  = (r_state == S_EXEC) && (r_req == REQ_ADD) && w_has_room;
        o_cell_ctl.upd  = (r_state == S_EXEC) && (r_req == REQ_UPDATE) && w_known;
        o_cell_ctl.id   = r_id;
        o_cell_ctl.load = r_load;
        o_pos           = (r_state == S_WALK) ? w_tail[IDX_W-1:0] : r_len[IDX_W-1:0];
    end

    // Sequence the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_rr        <= '0;
            r_known     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a finished result, or drop the one just taken
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= t_req'(i_req_type);
                        r_id    <= i_node_id;
                        r_load  <= i_load_value;
                        r_strat <= i_strategy;
                    end
                end
                S_EXEC: begin
                    r_sel      <= '0;
                    r_step     <= '0;
                    r_cur_len  <= r_len;
                    r_walk_len <= r_len;
                    case (r_req)
                        REQ_ADD: begin
                            if (w_has_room) begin
                                r_known[r_id] <= 1'b1;
                                r_len         <= r_len + CNT_W'(1);
                                r_status      <= ST_OK;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        REQ_REMOVE: begin
                            if (w_known) begin
                                r_known[r_id] <= 1'b0;
                                r_status      <= ST_OK;
                            end else begin
                                r_status <= ST_UNKNOWN;
                            end
                        end
                        REQ_UPDATE: begin
                            r_status <= w_known ? ST_OK : ST_UNKNOWN;
                        end
                        REQ_SELECT: begin
                            r_status <= (r_len == '0) ? ST_EMPTY : ST_OK;
                        end
                        default: r_status <= ST_OK;
                    endcase
                end
                S_WALK: begin
                    r_step    <= r_step + CNT_W'(1);
                    r_cur_len <= n_cur_len;
                    if (r_req == REQ_SELECT) begin
                        if (r_strat == STRAT_RR) begin
                            // capture the entry under the pointer, then advance with wrap
                            if (r_step == CNT_W'(w_rr_p)) begin
                                r_sel <= i_head_id;
                            end
                            if (w_last) begin
                                r_rr <= (w_rr_inc >= r_len) ? '0 : w_rr_inc[IDX_W-1:0];
                            end
                        end else if ((r_step == '0) || (i_head_load < r_best_load)) begin
                            // keep the first strictly lowest load
                            r_best_load <= i_head_load;
                            r_sel       <= i_head_id;
                        end
                    end else if (w_last) begin
                        // commit the compacted length, wrap a pointer past the end
                        r_len <= n_cur_len;
                        if (CNT_W'(r_rr) >= n_cur_len) begin
                            r_rr <= '0;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_status <= r_status;
                        r_out_sel    <= r_sel;
                        r_out_count  <= w_count;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_selected_node = r_out_sel;
    assign o_node_count    = r_out_count;

endmodule

@@ src/node_load_balancer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_load_balancer_unit
// Node list with add, remove, load update and round-robin or least-loaded
// select, built as a chain of list cells driven by a request sequencer.
// ----------------------------------------------------------------------------
// Flow: every request is accepted in idle, executed, and then moved into the
// output register. A remove of a known id and a select from a non-empty list
// also walk every entry listed before the request once through cell 0 (one
// entry per cycle) between execution and the output register. A new request
// is taken as soon as the sequencer is back in idle, even while the previous
// result still waits in the output register; a stalled output holds the next
// result in the sequencer until it drains.
// ----------------------------------------------------------------------------
module node_load_balancer_unit #(
    parameter int MAX_NODES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nlb_pkg::REQ_W-1:0]     i_req_type,
    input  logic [nlb_pkg::ID_W-1:0]      i_node_id,
    input  logic [nlb_pkg::LOAD_W-1:0]    i_load_value,
    input  logic                          i_strategy,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [nlb_pkg::ST_W-1:0]      o_status,
    output logic [nlb_pkg::ID_W-1:0]      o_selected_node,
    output logic [nlb_pkg::NC_W-1:0]      o_node_count
);
    import nlb_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);

    t_cell_ctl         w_ctl;
    logic [IDX_W-1:0]  w_pos;
    logic [ID_W-1:0]   w_id   [MAX_NODES];
    logic [LOAD_W-1:0] w_load [MAX_NODES];

    // Sequencer
    nlb_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_node_id       (i_node_id),
        .i_load_value    (i_load_value),
        .i_strategy      (i_strategy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_selected_node (o_selected_node),
        .o_node_count    (o_node_count),
        .i_head_id       (w_id[0]),
        .i_head_load     (w_load[0]),
        .o_cell_ctl      (w_ctl),
        .o_pos           (w_pos)
    );

    // Chain of list cells, each fed by its upper neighbor and the last by cell 0
    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        logic [ID_W-1:0]   w_next_id;
        logic [LOAD_W-1:0] w_next_load;

        if (g + 1 < MAX_NODES) begin : g_mid
            assign w_next_id   = w_id[g+1];
            assign w_next_load = w_load[g+1];
        end else begin : g_end
            assign w_next_id   = w_id[0];
            assign w_next_load = w_load[0];
        end

        nlb_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pos       (w_pos),
            .i_next_id   (w_next_id),
            .i_next_load (w_next_load),
            .i_head_id   (w_id[0]),
            .i_head_load (w_load[0]),
            .o_id        (w_id[g]),
            .o_load      (w_load[g])
        );
    end

endmodule

@@ src/nlb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlb_checker
// Port-level checks on the node selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nlb_checker #(
    parameter int MAX_NODES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [nlb_pkg::ST_W-1:0]      o_status,
    input  logic [nlb_pkg::ID_W-1:0]      o_selected_node,
    input  logic [nlb_pkg::NC_W-1:0]      o_node_count
);
    import nlb_pkg::*;

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_selected_node) && $stable(o_node_count), "stalled result changed")

    // Stall the input while an accepted request is executing
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "request accepted while busy")

    // Report an empty list only with a zero count and no node
    `ASSERT_IMPLIES(a_empty_result, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY), (o_node_count == '0) && (o_selected_node == '0), "empty status with entries")

    // Drop the node id on every failed request
    `ASSERT_IMPLIES(a_fail_no_node, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_selected_node == '0, "node reported on failure")

    // Keep the count within the list capacity
    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, o_out_valid, (MAX_NODES > 31) || (o_node_count <= MAX_NODES), "count beyond capacity")

endmodule

bind node_load_balancer_unit nlb_checker #(.MAX_NODES(MAX_NODES)) u_nlb_checker (.*);

@@ sim/node_load_balancer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_load_balancer_unit_tb
// Drives add, remove, load update and select requests into the node selector
// and checks every response against a behavioral copy of the node list, the
// round-robin pointer and the per-id load table. Both handshakes see random
// idle and stall bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module node_load_balancer_unit_tb;

    import nlb_pkg::*;

    localparam int MAX_NODES   = 16;
    localparam int WALK_CYCLES = MAX_NODES + 3;
    localparam int HANG_LIMIT  = 2000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] node;
        logic [NC_W-1:0] count;
    } t_outcome;

    // DUT connections, every input at a known value from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_req              i_req_type = REQ_ADD;
    logic [ID_W-1:0]   i_node_id = '0;
    logic [LOAD_W-1:0] i_load_value = '0;
    logic              i_strategy = STRAT_RR;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic [ID_W-1:0]   o_selected_node;
    logic [NC_W-1:0]   o_node_count;

    // Shadow of the block state
    logic [ID_W-1:0]   roster [MAX_NODES];
    int                roster_len;
    int                rr_next;
    bit                id_known [ID_SPACE];
    logic [LOAD_W-1:0] id_load [ID_SPACE];

    t_outcome          pending_outcomes [$];
    int                error_count;
    bit                quiet_tail;
    int                send_calm;
    int                stall_left;
    int                stall_calm;
    int                hang_count;
    logic [ID_W-1:0]   id_pool [8];

    node_load_balancer_unit #(
        .MAX_NODES(MAX_NODES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_node_id      (i_node_id),
        .i_load_value   (i_load_value),
        .i_strategy     (i_strategy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_selected_node(o_selected_node),
        .o_node_count   (o_node_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the shadow state and return the response it earns
    function automatic t_outcome apply_request(t_req kind, logic [ID_W-1:0] id,
                                               logic [LOAD_W-1:0] load, logic strat);
        t_outcome          res;
        int                w;
        int                pos;
        logic [ID_W-1:0]   best;
        logic [LOAD_W-1:0] best_load;
        res.status = ST_OK;
        res.node   = '0;
        case (kind)
            REQ_ADD: begin
                if (roster_len >= MAX_NODES) begin
                    res.status = ST_FULL;
                end else begin
                    id_load[id]        = '0;
                    id_known[id]       = 1'b1;
                    roster[roster_len] = id;
                    roster_len++;
                end
            end
            REQ_REMOVE: begin
                if (!id_known[id]) begin
                    res.status = ST_UNKNOWN;
                end else begin
                    // compact the list, keeping the order of the survivors
                    id_known[id] = 1'b0;
                    w = 0;
                    for (int r = 0; r < roster_len; r++) begin
                        if (roster[r] != id) begin
                            roster[w] = roster[r];
                            w++;
                        end
                    end
                    roster_len = w;
                    if (rr_next >= roster_len) rr_next = 0;
                end
            end
            REQ_UPDATE: begin
                if (id_known[id]) id_load[id] = load;
                else res.status = ST_UNKNOWN;
            end
            default: begin
                if (roster_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (strat == STRAT_LL) begin
                    // strict compare keeps the earliest entry on a tie
                    best      = roster[0];
                    best_load = id_load[best];
                    for (int i = 1; i < roster_len; i++) begin
                        if (id_load[roster[i]] < best_load) begin
                            best      = roster[i];
                            best_load = id_load[roster[i]];
                        end
                    end
                    res.node = best;
                end else begin
                    pos      = (rr_next < roster_len) ? rr_next : 0;
                    res.node = roster[pos];
                    pos++;
                    rr_next  = (pos >= roster_len) ? 0 : pos;
                end
            end
        endcase
        res.count = roster_len[NC_W-1:0];
        return res;
    endfunction

    // Present one request, hold it until taken, then record its response
    task automatic send_request(input t_req kind, input logic [ID_W-1:0] id,
                                input logic [LOAD_W-1:0] load, input logic strat);
        int gap;
        gap = 0;
        if (!quiet_tail) begin
            if (send_calm != 0) begin
                send_calm--;
            end else begin
                case ($urandom_range(0, 7))
                    0:       send_calm = $urandom_range(10, 40);
                    1, 2:    gap = $urandom_range(1, 6);
                    default: gap = 0;
                endcase
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_node_id    <= id;
        i_load_value <= load;
        i_strategy   <= strat;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_outcomes = {pending_outcomes, apply_request(kind, id, load, strat)};
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 7)];
        return ID_W'($urandom_range(0, ID_SPACE - 1));
    endfunction

    // Favor zero and a few repeated values so that ties come up often
    function automatic logic [LOAD_W-1:0] pick_load();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'h0100;
            3:       return 16'h0101;
            default: return LOAD_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_listed_id();
        if (roster_len != 0 && $urandom_range(0, 3) != 0)
            return roster[$urandom_range(0, roster_len - 1)];
        return pick_id();
    endfunction

    task automatic refill_pool();
        foreach (id_pool[k]) id_pool[k] = ID_W'($urandom_range(0, ID_SPACE - 1));
    endtask

    // Empty list corners: select, update and remove with nothing known
    task automatic test_empty_list();
        send_request(REQ_SELECT, 8'h00, 16'h0000, STRAT_RR);
        send_request(REQ_SELECT, 8'hFF, 16'hFFFF, STRAT_LL);
        send_request(REQ_UPDATE, 8'hFF, 16'hFFFF, STRAT_RR);
        send_request(REQ_REMOVE, 8'h00, 16'h0000, STRAT_LL);
    endtask

    // Duplicate add, ties, round-robin wrap and pointer wrap on remove
    task automatic test_basic_ops();
        send_request(REQ_ADD,    8'h00, 16'hFFFF, STRAT_LL);
        send_request(REQ_ADD,    8'hFF, 16'h0000, STRAT_RR);
        send_request(REQ_ADD,    8'hAA, 16'h5555, STRAT_RR);
        send_request(REQ_ADD,    8'h00, 16'hAAAA, STRAT_RR);
        send_request(REQ_UPDATE, 8'hFF, 16'hFFFF, STRAT_RR);
        send_request(REQ_UPDATE, 8'hAA, 16'h0000, STRAT_LL);
        send_request(REQ_SELECT, 8'h55, 16'h0000, STRAT_LL);
        repeat (4) send_request(REQ_SELECT, 8'h00, 16'h0000, STRAT_RR);
        send_request(REQ_REMOVE, 8'h00, 16'h0000, STRAT_RR);
        send_request(REQ_SELECT, 8'h00, 16'h0000, STRAT_RR);
        send_request(REQ_REMOVE, 8'hAA, 16'h0000, STRAT_RR);
        send_request(REQ_SELECT, 8'h00, 16'h0000, STRAT_RR);
        send_request(REQ_SELECT, 8'h00, 16'h0000, STRAT_LL);
    endtask

    // Fill past capacity, then drain with removes of mostly listed ids
    task automatic test_fill_and_drain();
        refill_pool();
        while (roster_len < MAX_NODES)
            send_request(REQ_ADD, pick_id(), pick_load(), 1'($urandom));
        send_request(REQ_ADD, pick_id(), pick_load(), 1'($urandom));
        send_request(REQ_UPDATE, pick_listed_id(), pick_load(), 1'($urandom));
        send_request(REQ_SELECT, pick_id(), pick_load(), STRAT_LL);
        send_request(REQ_SELECT, pick_id(), pick_load(), STRAT_RR);
        while (roster_len != 0)
            send_request(REQ_REMOVE, pick_listed_id(), pick_load(), 1'($urandom));
    endtask

    // Random traffic in grow or drain episodes picked at random
    task automatic test_random_mix(input int count);
        int   left;
        int   span;
        bit   grow;
        int   roll;
        t_req kind;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 3) == 0) refill_pool();
            grow = (roster_len < MAX_NODES / 2) ? ($urandom_range(0, 3) != 0)
                                                : ($urandom_range(0, 2) == 0);
            span = $urandom_range(15, 50);
            if (span > left) span = left;
            repeat (span) begin
                roll = $urandom_range(0, 99);
                if (grow)
                    kind = (roll < 45) ? REQ_ADD : (roll < 52) ? REQ_REMOVE :
                           (roll < 70) ? REQ_UPDATE : REQ_SELECT;
                else
                    kind = (roll < 10) ? REQ_ADD : (roll < 45) ? REQ_REMOVE :
                           (roll < 62) ? REQ_UPDATE : REQ_SELECT;
                if (kind == REQ_REMOVE || kind == REQ_UPDATE)
                    send_request(kind, pick_listed_id(), pick_load(), 1'($urandom));
                else
                    send_request(kind, pick_id(), pick_load(), 1'($urandom));
            end
            left -= span;
        end
    endtask

    // Output side stall bursts, with calm stretches and none at the tail
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet_tail) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (stall_calm != 0) begin
            stall_calm--;
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    stall_calm = $urandom_range(20, 60);
                    i_out_stall <= 1'b0;
                end
                1, 2: begin
                    stall_left = $urandom_range(1, 6) - 1;
                    i_out_stall <= 1'b1;
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // Compare each taken response with the oldest prediction
    always @(posedge i_clk) begin : check_responses
        t_outcome want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("%0t: response with none pending: status %0d node %0d count %0d",
                             $realtime, o_status, o_selected_node, o_node_count);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status || o_selected_node !== want.node ||
                    o_node_count !== want.count) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: exp status %0d node %0d count %0d, got %0d %0d %0d",
                                 $realtime, want.status, want.node, want.count,
                                 o_status, o_selected_node, o_node_count);
                end
            end
        end
    end

    // End the run when neither side has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            hang_count = 0;
        end else begin
            hang_count++;
            if (hang_count >= HANG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        roster_len  = 0;
        rr_next     = 0;
        error_count = 0;
        quiet_tail  = 1'b0;
        send_calm   = 0;
        stall_left  = 0;
        stall_calm  = 0;
        hang_count  = 0;
        foreach (id_known[k]) id_known[k] = 1'b0;
        refill_pool();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_fill_and_drain();
        test_random_mix(500);
        quiet_tail = 1'b1;
        test_random_mix(60);

        // drain every response, then give the block time for a stray one
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (WALK_CYCLES + 5) @(posedge i_clk);

        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
